FILE: hw/rtl/registration_retry_backoff_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the registration retry backoff core
// Shared concurrent assertion forms, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef REGISTRATION_RETRY_BACKOFF_CORE_DEFINES_SVH
`define REGISTRATION_RETRY_BACKOFF_CORE_DEFINES_SVH

`ifndef SYNTH
// Assertion checked on every clock edge outside reset.
`define RRB_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error(msg);
// Assertion checked on every clock edge, reset included.
`define RRB_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) (prop)) else $error(msg);
`else
`define RRB_ASSERT(lbl, clk_sig, rst_sig, prop, msg)
`define RRB_ASSERT_ALWAYS(lbl, clk_sig, prop, msg)
`endif

`endif

FILE: hw/rtl/rrb_pkg.sv
// ----------------------------------------------------------------------------
// Registration retry backoff package
// Types, codes and reset defaults shared by the retry backoff core.
// ----------------------------------------------------------------------------
package rrb_pkg;

  // Default width of the timeout, backoff and wait timers.
  localparam int TIMER_WIDTH_DEF = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 48;

  localparam int ATTEMPT_W  = 4;
  localparam int TIMEOUT_W  = 32;
  localparam int BASE_W     = 16;
  localparam int ELAPSED_W  = 32;
  // Backoff base shifted by at most fifteen places.
  localparam int BACKOFF_W  = BASE_W + (1 << ATTEMPT_W) - 1;

  localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX = '1;

  localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RST = 4'd5;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST      = 32'd10000;
  localparam logic [BASE_W-1:0]    BASE_RST         = 16'd2000;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ATTEMPTS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BACKOFF_BASE = 2'd2;

  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_START = 2'd1,
    FN_RESP  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_WAIT    = 3'd1,
    PH_BACKOFF = 3'd2,
    PH_DONE    = 3'd3,
    PH_FAILED  = 3'd4
  } phase_t;

endpackage

FILE: hw/rtl/registration_retry_backoff_core.sv
// An input transfer reaches its result through the input register, then the result register.
// One item per cycle unless m_axis_tready stalls the result; each item gives exactly one result.
// While a result waits for m_axis_tready, the input register takes an item only when empty.
// Reset (rst, synchronous, active high) returns the phase to idle, clears the attempt
// count and timers, empties both registers and loads the default configuration.
// ----------------------------------------------------------------------------
// Registration retry backoff core
// Request-and-retry controller with binary exponential backoff on a stream.
// ----------------------------------------------------------------------------
`include "registration_retry_backoff_core_defines.svh"

module registration_retry_backoff_core #(
  parameter int TIMER_WIDTH = rrb_pkg::TIMER_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rrb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rrb_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input items.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: func[1:0], response_ok[2], link_up[3], zero[7:4]
  input  logic [rrb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // Result items.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: send_request[0], succeeded[1], gave_up[2], status[5:3], attempts[9:6],
  //        elapsed_ticks[41:10], zero[47:42]
  output logic [rrb_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int CMP_W = (TIMER_WIDTH > 32) ? TIMER_WIDTH : 32;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;
  localparam logic [TIMER_WIDTH-1:0] TIMER_ONE = TIMER_WIDTH'(1);
  localparam logic [CMP_W-1:0] TIMER_MAX_EXT = CMP_W'(TIMER_MAX);
  localparam logic [CMP_W-1:0] ELAPSED_MAX_EXT = CMP_W'({rrb_pkg::ELAPSED_W{1'b1}});

  // Configuration registers.
  logic [rrb_pkg::ATTEMPT_W-1:0] max_attempts;
  logic [rrb_pkg::TIMEOUT_W-1:0] timeout_ticks;
  logic [rrb_pkg::BASE_W-1:0]    backoff_base_ticks;

  // Controller state.
  rrb_pkg::phase_t               phase, phase_next;
  logic [rrb_pkg::ATTEMPT_W-1:0] attempt_count, attempt_count_next;
  logic [TIMER_WIDTH-1:0]        remaining_ticks, remaining_ticks_next;
  logic [TIMER_WIDTH-1:0]        wait_count, wait_count_next;

  // Input register.
  logic                          in_valid;
  logic [rrb_pkg::IN_DATA_W-1:0] in_data;

  // Result register.
  logic                           out_valid;
  logic [rrb_pkg::OUT_DATA_W-1:0] out_data, out_data_next;

  logic advance;

  rrb_pkg::func_t func;
  logic response_ok;
  logic link_up;

  logic sent, success, failed;
  logic begin_att, attempt_fail, clear_count;
  logic [rrb_pkg::ATTEMPT_W-1:0] count_base;
  logic [rrb_pkg::ELAPSED_W-1:0] elapsed;

  logic [rrb_pkg::BACKOFF_W-1:0] backoff_raw;
  logic [CMP_W-1:0]              timeout_ext, backoff_ext, wait_ext;
  logic [TIMER_WIDTH-1:0]        timeout_sat, backoff_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_attempts       <= rrb_pkg::MAX_ATTEMPTS_RST;
      timeout_ticks      <= rrb_pkg::TIMEOUT_RST;
      backoff_base_ticks <= rrb_pkg::BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rrb_pkg::CFG_MAX_ATTEMPTS: max_attempts <= cfg_data[rrb_pkg::ATTEMPT_W-1:0];
        rrb_pkg::CFG_TIMEOUT:      timeout_ticks <= cfg_data[rrb_pkg::TIMEOUT_W-1:0];
        rrb_pkg::CFG_BACKOFF_BASE: backoff_base_ticks <= cfg_data[rrb_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // An item moves from the input register to the result register when the result
  // slot is empty or is being emptied in this cycle.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data <= s_axis_tdata;
    end
  end

  assign func        = rrb_pkg::func_t'(in_data[1:0]);
  assign response_ok = in_data[2];
  assign link_up     = in_data[3];

  // Saturated timer loads.
  assign backoff_raw = rrb_pkg::BACKOFF_W'(backoff_base_ticks) << attempt_count;
  assign timeout_ext = CMP_W'(timeout_ticks);
  assign backoff_ext = CMP_W'(backoff_raw);
  assign wait_ext    = CMP_W'(wait_count);
  assign timeout_sat = (timeout_ext > TIMER_MAX_EXT) ? TIMER_MAX
                                                     : timeout_ext[TIMER_WIDTH-1:0];
  assign backoff_sat = (backoff_ext > TIMER_MAX_EXT) ? TIMER_MAX
                                                     : backoff_ext[TIMER_WIDTH-1:0];

  // Next state.
  always_comb begin
    phase_next           = phase;
    attempt_count_next   = attempt_count;
    remaining_ticks_next = remaining_ticks;
    wait_count_next      = wait_count;
    sent                 = 1'b0;
    success              = 1'b0;
    failed               = 1'b0;
    elapsed              = '0;
    begin_att            = 1'b0;
    attempt_fail         = 1'b0;
    clear_count          = 1'b0;
    count_base           = attempt_count;

    case (func)
      rrb_pkg::FN_TICK: begin
        if (phase == rrb_pkg::PH_WAIT) begin
          if (wait_count != TIMER_MAX) begin
            wait_count_next = wait_count + TIMER_ONE;
          end
          if (remaining_ticks <= TIMER_ONE) begin
            remaining_ticks_next = '0;
            attempt_fail         = 1'b1;
          end else begin
            remaining_ticks_next = remaining_ticks - TIMER_ONE;
          end
        end else if (phase == rrb_pkg::PH_BACKOFF) begin
          if (remaining_ticks <= TIMER_ONE) begin
            remaining_ticks_next = '0;
            begin_att            = 1'b1;
          end else begin
            remaining_ticks_next = remaining_ticks - TIMER_ONE;
          end
        end
      end
      rrb_pkg::FN_START: begin
        if (phase != rrb_pkg::PH_WAIT && phase != rrb_pkg::PH_BACKOFF) begin
          clear_count = 1'b1;
          begin_att   = 1'b1;
        end
      end
      rrb_pkg::FN_RESP: begin
        if (phase == rrb_pkg::PH_WAIT) begin
          if (response_ok) begin
            phase_next           = rrb_pkg::PH_DONE;
            remaining_ticks_next = '0;
            success              = 1'b1;
            elapsed = (wait_ext > ELAPSED_MAX_EXT) ? '1 : wait_ext[rrb_pkg::ELAPSED_W-1:0];
          end else begin
            attempt_fail = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (begin_att) begin
      count_base = clear_count ? '0 : attempt_count;
      attempt_count_next = (count_base == rrb_pkg::ATTEMPT_MAX) ? count_base
                                                                : count_base + 1'b1;
      if (link_up) begin
        phase_next           = rrb_pkg::PH_WAIT;
        remaining_ticks_next = timeout_sat;
        wait_count_next      = '0;
        sent                 = 1'b1;
      end else begin
        phase_next           = rrb_pkg::PH_FAILED;
        remaining_ticks_next = '0;
        failed               = 1'b1;
      end
    end

    // Rejections and timeouts both compare against the count before this step.
    if (attempt_fail) begin
      if (attempt_count >= max_attempts) begin
        phase_next           = rrb_pkg::PH_FAILED;
        remaining_ticks_next = '0;
        failed               = 1'b1;
      end else begin
        phase_next           = rrb_pkg::PH_BACKOFF;
        remaining_ticks_next = backoff_sat;
      end
    end
  end

  // Result assembly.
  always_comb begin
    out_data_next = {
      {(rrb_pkg::OUT_DATA_W - 42){1'b0}},
      elapsed,
      attempt_count_next,
      phase_next,
      failed,
      success,
      sent
    };
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= rrb_pkg::PH_IDLE;
      attempt_count   <= '0;
      remaining_ticks <= '0;
      wait_count      <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      attempt_count   <= attempt_count_next;
      remaining_ticks <= remaining_ticks_next;
      wait_count      <= wait_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= out_data_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // A held result always reports the phase that the controller is in.
  `RRB_ASSERT(a_status_matches_phase, clk, rst,
              out_valid |-> (out_data[5:3] == phase), "result status differs from phase")
  // A single step never both succeeds and gives up.
  `RRB_ASSERT(a_success_excl_giveup, clk, rst,
              out_valid |-> !(out_data[1] && out_data[2]), "success and give-up together")
  // Giving up always leaves the controller in the failed phase.
  `RRB_ASSERT(a_giveup_failed, clk, rst,
              (out_valid && out_data[2]) |-> (phase == rrb_pkg::PH_FAILED),
              "give-up without failed phase")
  // An item waiting behind a stalled result is kept.
  `RRB_ASSERT(a_input_held, clk, rst,
              (in_valid && out_valid && !m_axis_tready) |=> in_valid,
              "input item lost during output stall")

endmodule
